>>> rtl/fmp_pkg.sv
package fmp_pkg;

  localparam int DATA_WIDTH_DEF  = 32;
  localparam int INDEX_WIDTH_DEF = 31;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_MULB,
    ST_FINISH
  } fmp_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic square;
    logic mul_base;
    logic shift;
    logic capture;
  } fmp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic exp_msb;
    logic index_zero;
  } fmp_sts_t;

endpackage

>>> rtl/fmp_ctrl.sv
module fmp_ctrl #(
  parameter int INDEX_WIDTH = fmp_pkg::INDEX_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  fmp_pkg::fmp_sts_t sts,
  output fmp_pkg::fmp_cmd_t cmd
);
  import fmp_pkg::*;

  localparam int CNT_W = (INDEX_WIDTH > 1) ? $clog2(INDEX_WIDTH) : 1;

  fmp_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             last_bit;
  logic             out_free;

  assign last_bit  = (cnt_r == '0);
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.index_zero ? ST_FINISH : ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (sts.exp_msb) begin
          state_nxt = ST_MULB;
        end else if (last_bit) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_MULB: begin
        state_nxt = last_bit ? ST_FINISH : ST_SQUARE;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE:   cmd.load = in_valid;
      ST_SQUARE: begin
        cmd.square = 1'b1;
        cmd.shift  = !sts.exp_msb;
      end
      ST_MULB: begin
        cmd.mul_base = 1'b1;
        cmd.shift    = 1'b1;
      end
      ST_FINISH: cmd.capture = out_free;
      default:   cmd = '0;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      cnt_nxt = CNT_W'(INDEX_WIDTH - 1);
    end else if (cmd.shift && !last_bit) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.capture) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/fmp_dp.sv
module fmp_dp #(
  parameter int DATA_WIDTH  = fmp_pkg::DATA_WIDTH_DEF,
  parameter int INDEX_WIDTH = fmp_pkg::INDEX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic [INDEX_WIDTH-1:0] in_index,
  input  fmp_pkg::fmp_cmd_t      cmd,
  output fmp_pkg::fmp_sts_t      sts,
  output logic [DATA_WIDTH-1:0]  out_fib_value
);
  import fmp_pkg::*;

  logic [DATA_WIDTH-1:0]  m_r [4];
  logic [DATA_WIDTH-1:0]  m_nxt [4];
  logic [INDEX_WIDTH-1:0] exp_r, exp_nxt;
  logic                   zero_r;
  logic [DATA_WIDTH-1:0]  out_r;
  logic [DATA_WIDTH-1:0]  sq [4];

  assign sts.exp_msb    = exp_r[INDEX_WIDTH-1];
  assign sts.index_zero = (in_index == '0);
  assign out_fib_value  = out_r;

  // Products keep only their low DATA_WIDTH bits, which is all the wrapped result needs.
  assign sq[0] = m_r[0] * m_r[0] + m_r[1] * m_r[2];
  assign sq[1] = m_r[0] * m_r[1] + m_r[1] * m_r[3];
  assign sq[2] = m_r[2] * m_r[0] + m_r[3] * m_r[2];
  assign sq[3] = m_r[2] * m_r[1] + m_r[3] * m_r[3];

  // The matrix starts as identity and every exponent bit is scanned; leading
  // zeros just square the identity, so no search for the top set bit is needed.
  always_comb begin
    m_nxt = m_r;
    if (cmd.load) begin
      m_nxt[0] = DATA_WIDTH'(1);
      m_nxt[1] = '0;
      m_nxt[2] = '0;
      m_nxt[3] = DATA_WIDTH'(1);
    end else if (cmd.square) begin
      m_nxt = sq;
    end else if (cmd.mul_base) begin
      m_nxt[0] = m_r[0] + m_r[1];
      m_nxt[1] = m_r[0];
      m_nxt[2] = m_r[2] + m_r[3];
      m_nxt[3] = m_r[2];
    end
  end

  always_comb begin
    exp_nxt = exp_r;
    if (cmd.load) begin
      exp_nxt = in_index - 1'b1;
    end else if (cmd.shift) begin
      exp_nxt = {exp_r[INDEX_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    m_r   <= m_nxt;
    exp_r <= exp_nxt;
    if (cmd.load) begin
      zero_r <= sts.index_zero;
    end
    if (cmd.capture) begin
      out_r <= zero_r ? '0 : m_r[0];
    end
  end

endmodule

>>> rtl/fibonacci_matrix_power.sv
// Returns F(in_index) modulo 2^DATA_WIDTH for each index taken in, one result per index.
// The 2x2 matrix starts as identity and, for each of the INDEX_WIDTH bits of index-1 from
// the top down, is squared with eight parallel multipliers and, where the bit is set, is
// then multiplied by [[1,1],[1,0]] in a state of its own; an index of zero skips the
// scan. The result register is loaded as the controller returns to idle, and the input
// reopens in that same cycle. One item is worked on at a time, and a new index is taken
// while the previous result still waits in the output register; a finished item whose
// result cannot be registered yet waits until that earlier result is transferred.
module fibonacci_matrix_power #(
  parameter int DATA_WIDTH  = fmp_pkg::DATA_WIDTH_DEF,
  parameter int INDEX_WIDTH = fmp_pkg::INDEX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [INDEX_WIDTH-1:0] in_index,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [DATA_WIDTH-1:0]  out_fib_value
);
  import fmp_pkg::*;

  fmp_cmd_t cmd;
  fmp_sts_t sts;

  fmp_ctrl #(
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fmp_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_dp (
    .clk          (clk),
    .in_index     (in_index),
    .cmd          (cmd),
    .sts          (sts),
    .out_fib_value(out_fib_value)
  );

endmodule

>>> rtl/fmp_checker.sv
module fmp_checker #(
  parameter int DATA_WIDTH  = fmp_pkg::DATA_WIDTH_DEF,
  parameter int INDEX_WIDTH = fmp_pkg::INDEX_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic [INDEX_WIDTH-1:0] in_index,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [DATA_WIDTH-1:0]  out_fib_value
);

  // Reset leaves no result pending and the input side open.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("result pending or input closed after reset");

  // A result waiting for the sink holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fib_value))
    else $error("stalled result changed");

  // An offered index that is not taken stays on the port unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_index))
    else $error("offered index dropped or changed before transfer");

  // The block works on one item at a time and gives no new result right after a transfer.
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !$rose(out_valid))
    else $error("input reopened or result appeared right after a transfer");

  // A new result is produced only as the block returns to idle.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result appeared while still busy");

endmodule

bind fibonacci_matrix_power fmp_checker #(
  .DATA_WIDTH (DATA_WIDTH),
  .INDEX_WIDTH(INDEX_WIDTH)
) u_fmp_checker (.*);

>>> tb/sv/fibonacci_matrix_power_tb.sv
`timescale 1ns / 1ps

module fibonacci_matrix_power_tb;

  localparam int DW = fmp_pkg::DATA_WIDTH_DEF;
  localparam int IW = fmp_pkg::INDEX_WIDTH_DEF;
  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 70;
  localparam int RANDOM_COUNT = 1750;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  logic [IW-1:0] in_index;
  logic          out_valid;
  logic          out_ready;
  logic [DW-1:0] out_fib_value;

  logic [DW-1:0] fib_expected[$];
  bit            idle_on;
  int            hold_cycles;
  int            fail_count;
  int            indices_sent;
  int            zero_sent;
  int            top_bit_sent;
  int            values_checked;
  int            quiet_cycles;

  fibonacci_matrix_power dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_index     (in_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_fib_value(out_fib_value)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // F(n) mod 2^DW: the power [[1,1],[1,0]]^(n-1) built by square-and-multiply,
  // scanning the exponent from just below its leading one.
  function automatic logic [DW-1:0] fib_mod(input logic [IW-1:0] n);
    logic [DW-1:0] a, b, c, d, sa, sb, sc, sd;
    logic [IW-1:0] e;
    int top;
    if (n == '0) return '0;
    a = DW'(1);
    b = DW'(1);
    c = DW'(1);
    d = '0;
    e = n - 1'b1;
    top = 0;
    for (int k = 0; k < IW; k++) if (e[k]) top = k;
    for (int k = top - 1; k >= 0; k--) begin
      sa = a * a + b * c;
      sb = a * b + b * d;
      sc = c * a + d * c;
      sd = c * b + d * d;
      if (e[k]) begin
        a = sa + sb;
        b = sa;
        c = sc + sd;
        d = sc;
      end else begin
        a = sa;
        b = sb;
        c = sc;
        d = sd;
      end
    end
    return a;
  endfunction

  function automatic logic [IW-1:0] random_index();
    logic [IW-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = IW'($urandom_range(0, 100));
      3: begin
        v = IW'(1);
        v = v << $urandom_range(0, IW - 1);
        v = v + IW'($urandom_range(0, 2)) - 1'b1;
      end
      4: v = '0;
      default: v = IW'($urandom());
    endcase
    return v;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic send_index(input logic [IW-1:0] idx);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_index <= idx;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    fib_expected.push_back(fib_mod(idx));
    indices_sent++;
    if (idx == '0) zero_sent++;
    if (idx[IW-1]) top_bit_sent++;
  endtask

  // Drops valid and waits for every outstanding result to be transferred.
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (fib_expected.size() == 0);
  endtask

  task automatic test_small_indices();
    for (int i = 0; i <= 5; i++) send_index(IW'(i));
    send_index(IW'(47));
    send_index(IW'(48));
    send_index(IW'(93));
    send_index('0);
    send_index('0);
  endtask

  task automatic test_range_extremes();
    logic [IW-1:0] one_hot;
    one_hot = IW'(1);
    send_index({IW{1'b1}});
    send_index('0);
    send_index(one_hot << (IW - 1));
    send_index((one_hot << (IW - 1)) + 1'b1);
    send_index((one_hot << (IW - 1)) - 1'b1);
    send_index(IW'({(IW + 1) / 2{2'b01}}));
    send_index(IW'({(IW + 1) / 2{2'b10}}));
    send_index(one_hot << 16);
    send_index((one_hot << 16) + 1'b1);
    send_index(IW'(1000000007));
  endtask

  // The receiver holds off long enough that the block fills and refuses input.
  task automatic test_receiver_hold();
    wait_for_drain();
    idle_on = 1'b0;
    hold_cycles = 300;
    for (int i = 0; i < 8; i++) send_index(random_index());
    idle_on = 1'b1;
  endtask

  task automatic test_sender_pause();
    for (int i = 0; i < 5; i++) send_index(random_index());
    wait_for_drain();
    for (int i = 0; i < 5; i++) send_index(random_index());
  endtask

  task automatic test_random_indices(input int count);
    for (int i = 0; i < count; i++) begin
      // Every third stretch of 150 items runs with no idling on either side.
      idle_on = ((i / 150) % 3) != 2;
      send_index(random_index());
    end
    idle_on = 1'b1;
  endtask

  // Result side: ready either goes high ahead of valid or only after valid has
  // waited a while, so stalls land both before and during a pending result.
  initial begin
    int  stall;
    bit  eager;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      stall = idle_on ? $urandom_range(0, 5) : 0;
      eager = $urandom_range(0, 1);
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end
      @(negedge clk);
      if (!eager || stall > 0) out_ready <= 1'b0;
      if (!eager) begin
        do @(posedge clk); while (!out_valid);
        @(negedge clk);
      end
      repeat (stall) @(negedge clk);
      out_ready <= 1'b1;
      forever begin
        @(posedge clk);
        if (out_valid) break;
      end
    end
  end

  always @(posedge clk) begin
    logic [DW-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      values_checked++;
      if (fib_expected.size() == 0) begin
        note_failure($sformatf("unexpected result %0d", out_fib_value));
      end else begin
        want = fib_expected.pop_front();
        if (out_fib_value !== want)
          note_failure($sformatf("fib_value expected %0d, got %0d", want, out_fib_value));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else if (in_valid || fib_expected.size() > 0) begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("ERROR: no transfer for %0d cycles", quiet_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_index = '0;
    idle_on = 1'b1;
    hold_cycles = 0;
    fail_count = 0;
    indices_sent = 0;
    zero_sent = 0;
    top_bit_sent = 0;
    values_checked = 0;
    quiet_cycles = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_small_indices();
    test_range_extremes();
    test_receiver_hold();
    test_sender_pause();
    test_random_indices(RANDOM_COUNT);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fib_expected.size() > 0)
      note_failure($sformatf("%0d results never arrived", fib_expected.size()));
    $display("Sent %0d indices (%0d of them zero, %0d with the top bit set);",
             indices_sent, zero_sent, top_bit_sent);
    $display("compared %0d Fibonacci values, %0d failures.", values_checked, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
